// ===== design/distinct_value_filter_unit_defines.svh =====
// Assertion macros shared by the checker of the distinct value filter unit.
`ifndef DISTINCT_VALUE_FILTER_UNIT_DEFINES_SVH
`define DISTINCT_VALUE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dvf_pkg.sv =====
// Package with shared types and constants of the distinct value filter unit.
`timescale 1ns / 1ps
package dvf_pkg;

  localparam int DVF_CAPACITY = 128;
  localparam int DVF_VALUE_W  = 32;
  localparam int DVF_SLOT_W   = 7;
  localparam int DVF_COUNT_W  = 8;
  localparam int DVF_QPTR_W   = 1;
  localparam int DVF_QDEPTH   = 2;

  typedef struct packed {
    logic signed [DVF_VALUE_W-1:0] value;
    logic                          last_item;
  } dvf_item_t;

endpackage

// ===== design/dvf_front.sv =====
// Front end: accepts items and holds them in a short queue for the search engine.
`timescale 1ns / 1ps
module dvf_front
  import dvf_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DVF_VALUE_W-1:0] in_value,
  input  logic                          in_last_item,
  output logic                          q_valid,
  input  logic                          q_ready,
  output dvf_item_t                     q_item
);

  dvf_item_t             entry_r [DVF_QDEPTH];
  logic [DVF_QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DVF_QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [DVF_QPTR_W:0]   fill_r, fill_nxt;
  logic                  push;
  logic                  pop;

  assign in_ready = (fill_r != (DVF_QPTR_W + 1)'(DVF_QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = entry_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r].value     <= in_value;
      entry_r[wr_ptr_r].last_item <= in_last_item;
    end
  end

endmodule

// ===== design/dvf_back.sv =====
// Back end: scans the value store one entry per cycle, appends new values, registers results.
`timescale 1ns / 1ps
module dvf_back
  import dvf_pkg::*;
#(
  parameter int CAPACITY = DVF_CAPACITY
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  dvf_item_t              q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_is_new,
  output logic [DVF_SLOT_W-1:0]  out_slot,
  output logic                   out_overflow,
  output logic [DVF_COUNT_W-1:0] out_distinct_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [DVF_VALUE_W-1:0] store_mem [CAPACITY];
  logic [DVF_VALUE_W-1:0] rd_data_r;

  logic                   state_r, state_nxt;
  dvf_item_t              cur_r, cur_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_is_new_r, out_is_new_nxt;
  logic [DVF_SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                   out_overflow_r, out_overflow_nxt;
  logic [DVF_COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                   rd_en;
  logic                   wr_en;
  logic                   hit;
  logic                   miss;
  logic                   full;
  logic                   out_free;
  logic [IW-1:0]          slot_sel;
  logic [CW-1:0]          cnt_after;
  logic [31:0]            slot_ext;
  logic [31:0]            count_ext;

  assign full      = (cnt_r == CAP_C);
  assign hit       = chk_vld_r && (rd_data_r == cur_r.value);
  assign miss      = !chk_vld_r && (idx_r == cnt_r);
  assign out_free  = !out_valid_r || out_ready;
  assign slot_sel  = hit ? chk_idx_r : (full ? '0 : cnt_r[IW-1:0]);
  assign cnt_after = (miss && !full) ? cnt_r + CW'(1) : cnt_r;
  assign slot_ext  = 32'(slot_sel);
  assign count_ext = 32'(cnt_after);

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    cnt_nxt          = cnt_r;
    idx_nxt          = idx_r;
    chk_vld_nxt      = chk_vld_r;
    chk_idx_nxt      = chk_idx_r;
    out_valid_nxt    = out_valid_r;
    out_is_new_nxt   = out_is_new_r;
    out_slot_nxt     = out_slot_r;
    out_overflow_nxt = out_overflow_r;
    out_count_nxt    = out_count_r;
    q_ready          = 1'b0;
    rd_en            = 1'b0;
    wr_en            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_nxt     = q_item;
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          if (out_free) begin
            wr_en            = miss && !full;
            out_valid_nxt    = 1'b1;
            out_is_new_nxt   = !hit;
            out_overflow_nxt = miss && full;
            out_slot_nxt     = slot_ext[DVF_SLOT_W-1:0];
            out_count_nxt    = count_ext[DVF_COUNT_W-1:0];
            cnt_nxt          = cur_r.last_item ? '0 : cnt_after;
            chk_vld_nxt      = 1'b0;
            state_nxt        = ST_IDLE;
          end
        end else begin
          rd_en = 1'b1;
          if (idx_r != cnt_r) begin
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = idx_r[IW-1:0];
            idx_nxt     = idx_r + CW'(1);
          end else begin
            chk_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    chk_idx_r      <= chk_idx_nxt;
    out_is_new_r   <= out_is_new_nxt;
    out_slot_r     <= out_slot_nxt;
    out_overflow_r <= out_overflow_nxt;
    out_count_r    <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[cnt_r[IW-1:0]] <= cur_r.value;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[idx_r[IW-1:0]];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = out_is_new_r;
  assign out_slot           = out_slot_r;
  assign out_overflow       = out_overflow_r;
  assign out_distinct_count = out_count_r;

endmodule

// ===== design/distinct_value_filter_unit.sv =====
// Sequential: with N values stored, a new value is compared against all N stored entries,
// and a repeat found at slot k stops the scan there; the input queue registers each item and
// the engine returns to idle after each result, so it takes no new item before the last is done.
// The two-entry queue accepts items during a search.
// A finished result waits in the output register while the next item is searched.
// Reset is synchronous and active low; it empties the queue, output and set, not the memory.
`timescale 1ns / 1ps
module distinct_value_filter_unit
  import dvf_pkg::*;
#(
  parameter int CAPACITY = DVF_CAPACITY
)
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DVF_VALUE_W-1:0] in_value,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_new,
  output logic [DVF_SLOT_W-1:0]         out_slot,
  output logic                          out_overflow,
  output logic [DVF_COUNT_W-1:0]        out_distinct_count
);

  logic      q_valid;
  logic      q_ready;
  dvf_item_t q_item;

  dvf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last_item (in_last_item),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  dvf_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_item             (q_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_new         (out_is_new),
    .out_slot           (out_slot),
    .out_overflow       (out_overflow),
    .out_distinct_count (out_distinct_count)
  );

endmodule

// ===== design/dvf_checker.sv =====
// Port-level checker of the distinct value filter unit and its bind statement.
`timescale 1ns / 1ps
`include "distinct_value_filter_unit_defines.svh"
module dvf_checker
  import dvf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_is_new,
  input logic [DVF_SLOT_W-1:0]  out_slot,
  input logic                   out_overflow,
  input logic [DVF_COUNT_W-1:0] out_distinct_count
);

  `DVF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped before the item was taken")
  `DVF_ASSERT_IMPL(a_ovf_new, clk, rst_n, out_valid && out_overflow, out_is_new, "overflow reported for a stored value")
  `DVF_ASSERT_IMPL(a_ovf_slot, clk, rst_n, out_valid && out_overflow, out_slot == '0, "overflow result carries a nonzero slot")
  `DVF_ASSERT_IMPL(a_new_count, clk, rst_n, out_valid && out_is_new && !out_overflow, out_distinct_count != '0, "appended value reported with zero count")

endmodule

bind distinct_value_filter_unit dvf_checker u_dvf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_is_new         (out_is_new),
  .out_slot           (out_slot),
  .out_overflow       (out_overflow),
  .out_distinct_count (out_distinct_count)
);

// ===== verif/tb_distinct_value_filter_unit.sv =====
// Self-checking testbench for the distinct value filter unit with a scoreboard class.
`timescale 1ns / 1ps
module tb_distinct_value_filter_unit;
  import dvf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * DVF_CAPACITY + 20;
  localparam int REPORT_MAX   = 10;
  localparam int TAG_W        = DVF_VALUE_W - DVF_SLOT_W;

  typedef struct packed {
    logic                   is_new;
    logic [DVF_SLOT_W-1:0]  slot;
    logic                   overflow;
    logic [DVF_COUNT_W-1:0] distinct_count;
  } dvf_result_t;

  class distinct_set_tracker;
    logic [DVF_VALUE_W-1:0] held_values [DVF_CAPACITY];
    int held_count = 0;
    dvf_result_t pending_results[$];
    int mismatches = 0;
    int items_seen = 0;
    int results_seen = 0;
    int new_seen = 0;
    int repeat_seen = 0;
    int dropped_seen = 0;
    int sets_closed = 0;

    function void note_item(logic [DVF_VALUE_W-1:0] value, logic last);
      dvf_result_t r;
      int hit_at;
      hit_at = -1;
      for (int i = 0; i < held_count; i++) begin
        if (hit_at < 0 && held_values[i] == value) hit_at = i;
      end
      r.overflow = 1'b0;
      if (hit_at >= 0) begin
        r.is_new = 1'b0;
        r.slot = DVF_SLOT_W'(hit_at);
        repeat_seen++;
      end else if (held_count < DVF_CAPACITY) begin
        r.is_new = 1'b1;
        r.slot = DVF_SLOT_W'(held_count);
        held_values[held_count] = value;
        held_count++;
        new_seen++;
      end else begin
        r.is_new = 1'b1;
        r.overflow = 1'b1;
        r.slot = '0;
        dropped_seen++;
      end
      r.distinct_count = DVF_COUNT_W'(held_count);
      if (last) begin
        held_count = 0;
        sets_closed++;
      end
      pending_results.push_back(r);
      items_seen++;
    endfunction

    function void check_result(dvf_result_t got);
      dvf_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Result with no item pending: new=%0b slot=%0d ovf=%0b count=%0d",
                   got.is_new, got.slot, got.overflow, got.distinct_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.is_new !== want.is_new || got.slot !== want.slot ||
          got.overflow !== want.overflow || got.distinct_count !== want.distinct_count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Mismatch on result %0d: expected new=%0b slot=%0d ovf=%0b count=%0d, %s",
                   results_seen, want.is_new, want.slot, want.overflow, want.distinct_count,
                   $sformatf("got new=%0b slot=%0d ovf=%0b count=%0d", got.is_new, got.slot,
                             got.overflow, got.distinct_count));
      end
      results_seen++;
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [DVF_VALUE_W-1:0] in_value = '0;
  logic                          in_last_item = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_is_new;
  logic [DVF_SLOT_W-1:0]         out_slot;
  logic                          out_overflow;
  logic [DVF_COUNT_W-1:0]        out_distinct_count;

  distinct_set_tracker tracker = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  distinct_value_filter_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_value           (in_value),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_is_new         (out_is_new),
    .out_slot           (out_slot),
    .out_overflow       (out_overflow),
    .out_distinct_count (out_distinct_count)
  );

  always #CLK_HALF clk = ~clk;

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result({out_is_new, out_slot, out_overflow, out_distinct_count});
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  task automatic send_item(input logic [DVF_VALUE_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= value;
    in_last_item <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(value, last);
    @(negedge clk);
  endtask

  function automatic logic [DVF_VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return DVF_VALUE_W'($urandom_range(8));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_short_set();
    logic [DVF_VALUE_W-1:0] pool [16];
    int pool_size;
    int len;
    pool_size = $urandom_range(1, 16);
    len = $urandom_range(1, 24);
    for (int i = 0; i < pool_size; i++) pool[i] = pick_value();
    for (int i = 0; i < len; i++) send_item(pool[$urandom_range(pool_size - 1)], i == len - 1);
  endtask

  // Fills the store completely, then mixes repeats with values that no longer fit.
  task automatic send_full_set(input int extra);
    logic [DVF_VALUE_W-1:0] kept [DVF_CAPACITY];
    logic [TAG_W-1:0] tag;
    for (int i = 0; i < DVF_CAPACITY; i++) begin
      tag = TAG_W'($urandom());
      kept[i] = {tag, DVF_SLOT_W'(i)};
      send_item(kept[i], 1'b0);
    end
    for (int i = 0; i < extra; i++) begin
      if ($urandom_range(1)) send_item(kept[$urandom_range(DVF_CAPACITY - 1)], i == extra - 1);
      else send_item($urandom(), i == extra - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int first;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = tracker.items_seen;
    send_full_set($urandom_range(8, 30));
    while (tracker.items_seen - first < n_items) send_short_set();
  endtask

  initial begin : stimulus
    int missing;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h7fff_fffe, 1'b0);
    send_item(32'hffff_fffe, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'haaaa_aaaa, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    send_item(32'h0000_0000, 1'b1);

    run_phase(0, 0, 300);
    run_phase(83, 0, 300);
    run_phase(0, 83, 300);
    run_phase(21, 21, 300);
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    missing = tracker.pending_results.size();
    $display("Sent %0d items in %0d sets: %0d new, %0d repeats, %0d dropped on a full store.",
             tracker.items_seen, tracker.sets_closed, tracker.new_seen, tracker.repeat_seen,
             tracker.dropped_seen);
    $display("Handshake idling ran without gaps, with a slow sender, a slow receiver and both.");
    if (tracker.mismatches == 0 && missing == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tracker.mismatches, missing);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
